>>> rtl/dmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// dmc_pkg: grid geometry, sequencer states, codes and probe offset helpers
// for the maze carver. No dependencies.

package dmc_pkg;

  // grid geometry
  localparam int GRID_W = 32;
  localparam int GRID_H = 32;
  localparam int CELLS  = GRID_W * GRID_H;
  localparam int XW     = $clog2(GRID_W);
  localparam int YW     = $clog2(GRID_H);
  localparam int CW     = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int ENT_W  = XW + YW;
  localparam int SW     = ((XW > YW) ? XW : YW) + 2;

  // port field widths
  localparam int COORD_OUT_W = 5;
  localparam int CFG_W       = 5;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  typedef logic [XW-1:0]        xcrd_t;
  typedef logic [YW-1:0]        ycrd_t;
  typedef logic [CW-1:0]        addr_t;
  typedef logic signed [SW-1:0] scrd_t;
  typedef logic signed [2:0]    off_t;

  // register indexes
  localparam logic REG_START_X = 1'b0;
  localparam logic REG_START_Y = 1'b1;

  // commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_FORCED = 2'd1,
    ACT_BRANCH = 2'd2,
    ACT_BACK   = 2'd3
  } action_t;

  // directions
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;
  localparam logic [1:0] DIR_LAST = 2'd3;

  // probe cells around a target, in checking order
  localparam logic [2:0] PRB_TGT    = 3'd0;
  localparam logic [2:0] PRB_FAR    = 3'd1;
  localparam logic [2:0] PRB_SIDE_A = 3'd2;
  localparam logic [2:0] PRB_SIDE_B = 3'd3;
  localparam logic [2:0] PRB_FAR_A  = 3'd4;
  localparam logic [2:0] PRB_FAR_B  = 3'd5;

  // sequencer states
  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_PROBE  = 7'b0000100,
    S_EVAL   = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_POP    = 7'b0100000,
    S_WRITE  = 7'b1000000
  } state_t;

  // offset of a probe from the current cell, one axis at a time
  function automatic off_t probe_off(input off_t dm, input off_t pm, input logic [2:0] j);
    off_t r;
    case (j)
      PRB_TGT:    r = dm;
      PRB_FAR:    r = dm + dm;
      PRB_SIDE_A: r = dm + pm;
      PRB_SIDE_B: r = dm - pm;
      PRB_FAR_A:  r = dm + dm + pm;
      PRB_FAR_B:  r = dm + dm - pm;
      default:    r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic off_t off_x(input logic [1:0] d, input logic [2:0] j);
    off_t dx;
    off_t px;
    dx = (d == DIR_E) ? 3'sd1 : ((d == DIR_W) ? -3'sd1 : 3'sd0);
    px = ((d == DIR_N) || (d == DIR_S)) ? 3'sd1 : 3'sd0;
    return probe_off(dx, px, j);
  endfunction

  function automatic off_t off_y(input logic [1:0] d, input logic [2:0] j);
    off_t dy;
    off_t py;
    dy = (d == DIR_S) ? 3'sd1 : ((d == DIR_N) ? -3'sd1 : 3'sd0);
    py = ((d == DIR_E) || (d == DIR_W)) ? 3'sd1 : 3'sd0;
    return probe_off(dy, py, j);
  endfunction

  function automatic addr_t cell_addr(input xcrd_t x, input ycrd_t y);
    return CW'(int'(y) * GRID_W + int'(x));
  endfunction

endpackage

`default_nettype wire

>>> rtl/dfs_maze_carver.sv
`timescale 1ns / 1ps
`default_nettype none
// dfs_maze_carver: maze carver top level with grid bitmap, backtrack stack
// and probe sequencer. Depends on dmc_pkg.

// Carves a maze at most one cell per step word by a randomized depth-first walk.
// A step word probes up to six grid cells around each of the four neighbors
// through one bitmap read port, each probe passing a probe and an eval state,
// with early exit on the first failing probe; a backtrack adds a pop state
// for the stack read. A start word sweeps the whole bitmap back to walls,
// one cell a cycle, and then writes the start result. A result that has not
// been taken yet holds the next result back until it is taken.
// After reset the same clearing pass runs with the input not ready;
// configuration writes are taken at any time. One word is worked on at a
// time, and a new word is taken while the last result waits.

module dfs_maze_carver (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [1:0] random_pick
  input  wire logic [0:0]                    s_axis_tuser,  // [0] cmd
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [15:0]                        m_axis_tdata,  // [4:0] cell_x, [9:5] cell_y
  output logic [1:0]                         m_axis_tuser,  // [1:0] action
  output logic                               m_axis_tlast,  // done_res
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dmc_pkg::APB_AW-1:0]    paddr,
  input  wire logic [dmc_pkg::APB_DW-1:0]    pwdata,
  output logic [dmc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import dmc_pkg::*;

  state_t state;

  // configuration registers
  logic [CFG_W-1:0] start_x;
  logic [CFG_W-1:0] start_y;
  logic             cfg_we;
  xcrd_t            st_x;
  ycrd_t            st_y;

  // walk state
  xcrd_t            cur_x;
  ycrd_t            cur_y;
  logic [CNT_W-1:0] stk_cnt;
  logic             finished;
  logic [1:0]       pick;
  action_t          act;
  logic             clr_start;
  addr_t            clr_idx;

  // probe sequencer
  logic [1:0]       dir_cnt;
  logic [2:0]       prb_cnt;
  logic [3:0]       vmask;
  scrd_t            prb_x;
  scrd_t            prb_y;
  logic             in_grid;
  logic             interior;
  logic             bad;
  addr_t            prb_addr;

  // memories
  logic             open_map [CELLS];
  logic             map_rdata;
  logic             map_we;
  addr_t            map_waddr;
  logic             map_wdata;
  logic [ENT_W-1:0] stk_mem [CELLS];
  logic [ENT_W-1:0] stk_rdata;
  addr_t            stk_raddr;
  logic             push;

  // decision
  logic [2:0]       nvalid;
  logic [1:0]       rot_d;
  logic             rot_found;
  xcrd_t            nx;
  ycrd_t            ny;
  logic             out_free;
  logic             done_now;

  // apb port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= CFG_W'(1);
      start_y <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_START_X: start_x <= pwdata[CFG_W-1:0];
        REG_START_Y: start_y <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_START_X: prdata = APB_DW'(start_x);
      REG_START_Y: prdata = APB_DW'(start_y);
    endcase
  end

  // start cell clamped into the interior
  always_comb begin
    if (start_x == '0) st_x = xcrd_t'(1);
    else if (int'(start_x) > GRID_W - 2) st_x = xcrd_t'(GRID_W - 2);
    else st_x = xcrd_t'(start_x);
    if (start_y == '0) st_y = ycrd_t'(1);
    else if (int'(start_y) > GRID_H - 2) st_y = ycrd_t'(GRID_H - 2);
    else st_y = ycrd_t'(start_y);
  end

  // probe address and checks for the current direction and probe index
  always_comb begin
    prb_x    = scrd_t'($signed({1'b0, cur_x})) + scrd_t'(off_x(dir_cnt, prb_cnt));
    prb_y    = scrd_t'($signed({1'b0, cur_y})) + scrd_t'(off_y(dir_cnt, prb_cnt));
    in_grid  = (prb_x >= 0) && (prb_x < scrd_t'(GRID_W)) &&
               (prb_y >= 0) && (prb_y < scrd_t'(GRID_H));
    interior = (prb_x > 0) && (prb_x < scrd_t'(GRID_W - 1)) &&
               (prb_y > 0) && (prb_y < scrd_t'(GRID_H - 1));
    prb_addr = cell_addr(xcrd_t'(prb_x), ycrd_t'(prb_y));
    bad      = (in_grid && map_rdata) || ((prb_cnt == PRB_TGT) && !interior);
  end

  // direction choice: first valid one in rotation from the pick
  always_comb begin
    nvalid    = 3'($countones(vmask));
    rot_d     = pick;
    rot_found = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!rot_found && vmask[pick + 2'(k)]) begin
        rot_d     = pick + 2'(k);
        rot_found = 1'b1;
      end
    end
    nx = cur_x + xcrd_t'(off_x(rot_d, PRB_TGT));
    ny = cur_y + ycrd_t'(off_y(rot_d, PRB_TGT));
  end

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign done_now  = (act != ACT_START) && (stk_cnt == '0);
  assign push      = (state == S_DECIDE) && (nvalid > 3'd1) && (stk_cnt < CNT_W'(CELLS));
  assign stk_raddr = CW'(stk_cnt - CNT_W'(1));

  // bitmap write select: clearing sweep or opening the reached cell
  always_comb begin
    map_we    = (state == S_CLEAR) || ((state == S_WRITE) && out_free);
    map_waddr = (state == S_CLEAR) ? clr_idx : cell_addr(cur_x, cur_y);
    map_wdata = (state == S_WRITE);
  end

  // grid bitmap
  always_ff @(posedge clk) begin
    if (map_we) open_map[map_waddr] <= map_wdata;
    map_rdata <= open_map[prb_addr];
  end

  // backtrack stack, read port always points at the top entry
  always_ff @(posedge clk) begin
    if (push) stk_mem[CW'(stk_cnt)] <= {cur_y, cur_x};
    stk_rdata <= stk_mem[stk_raddr];
  end

  assign s_axis_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      clr_start <= 1'b0;
      cur_x     <= xcrd_t'(1);
      cur_y     <= ycrd_t'(1);
      stk_cnt   <= '0;
      finished  <= 1'b0;
      dir_cnt   <= '0;
      prb_cnt   <= '0;
      vmask     <= '0;
      act       <= ACT_START;
      pick      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // result valid: raised when a word is written out, dropped once taken
      if ((state == S_WRITE) && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + addr_t'(1);
          if (clr_idx == addr_t'(CELLS - 1)) begin
            if (clr_start) begin
              cur_x <= st_x;
              cur_y <= st_y;
              act   <= ACT_START;
              state <= S_WRITE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pick <= s_axis_tdata[1:0];
            if (s_axis_tuser[0] == CMD_START) begin
              finished  <= 1'b0;
              stk_cnt   <= '0;
              clr_idx   <= '0;
              clr_start <= 1'b1;
              state     <= S_CLEAR;
            end else if (finished) begin
              act   <= ACT_BACK;
              state <= S_WRITE;
            end else begin
              vmask   <= 4'b1111;
              dir_cnt <= DIR_N;
              prb_cnt <= PRB_TGT;
              state   <= S_PROBE;
            end
          end
        end
        S_PROBE: state <= S_EVAL;
        S_EVAL: begin
          if (bad) vmask[dir_cnt] <= 1'b0;
          if (bad || (prb_cnt == PRB_FAR_B)) begin
            prb_cnt <= PRB_TGT;
            dir_cnt <= dir_cnt + 2'd1;
            state   <= (dir_cnt == DIR_LAST) ? S_DECIDE : S_PROBE;
          end else begin
            prb_cnt <= prb_cnt + 3'd1;
            state   <= S_PROBE;
          end
        end
        S_DECIDE: begin
          if (nvalid == 3'd0) begin
            act <= ACT_BACK;
            if (stk_cnt != '0) begin
              stk_cnt <= stk_cnt - CNT_W'(1);
              state   <= S_POP;
            end else begin
              state <= S_WRITE;
            end
          end else begin
            cur_x <= nx;
            cur_y <= ny;
            act   <= (nvalid == 3'd1) ? ACT_FORCED : ACT_BRANCH;
            if (push) stk_cnt <= stk_cnt + CNT_W'(1);
            state <= S_WRITE;
          end
        end
        S_POP: begin
          cur_x <= stk_rdata[XW-1:0];
          cur_y <= stk_rdata[ENT_W-1:XW];
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            if (act != ACT_START) finished <= done_now;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if ((state == S_WRITE) && out_free) begin
      m_axis_tdata <= {6'd0, COORD_OUT_W'(cur_y), COORD_OUT_W'(cur_x)};
      m_axis_tuser <= act;
      m_axis_tlast <= done_now;
    end
  end

  // checks
  a_stk_bound: assert property (@(posedge clk) disable iff (rst)
    stk_cnt <= CNT_W'(CELLS))
    else $error("backtrack stack count past depth");

  a_finished_empty: assert property (@(posedge clk) disable iff (rst)
    finished |-> (stk_cnt == '0))
    else $error("finished with entries left on the stack");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after taking a word");

  a_start_not_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ACT_START)) |-> !m_axis_tlast)
    else $error("start result flagged as complete");

endmodule

`default_nettype wire
